FILE: rtl/brv_pkg.sv
// ----------------------------------------------------------------------------
// brv_pkg
// shared types and constants of the register vm executor
// ----------------------------------------------------------------------------
package brv_pkg;

    localparam int NUM_REGS_DEF   = 256;
    localparam int WORD_BITS_DEF  = 32;
    localparam int PROG_DEPTH_DEF = 256;

    typedef enum logic [4:0] {
        OP_NONE  = 5'd0,  OP_ADD  = 5'd1,  OP_SUB  = 5'd2,  OP_MUL   = 5'd3,
        OP_DIV   = 5'd4,  OP_MOD  = 5'd5,  OP_INC  = 5'd6,  OP_NEG   = 5'd7,
        OP_JMP   = 5'd8,  OP_JNE  = 5'd9,  OP_JE   = 5'd10, OP_MOV   = 5'd11,
        OP_TST   = 5'd12, OP_AND  = 5'd13, OP_OR   = 5'd14, OP_XOR   = 5'd15,
        OP_NOT   = 5'd16, OP_LSH  = 5'd17, OP_RSH  = 5'd18, OP_PRINT = 5'd19,
        OP_STALL = 5'd20
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_OUT
    } state_t;

    typedef struct packed {
        logic operand_rd;   // read register file at a and b
        logic exec;         // compute result, write back, load output
        logic div_start;
        logic div_finish;   // write back divider result, load output
        logic out_clear;    // output word taken
    } ctrl_t;

    typedef struct packed {
        logic is_div;       // current item needs the divider (div/mod, nonzero b, not halted)
        logic div_done;
    } stat_t;

    typedef struct packed {
        logic [4:0] func;
        logic [7:0] first_field;
        logic [7:0] second_field;
        logic [7:0] third_field;
    } instr_t;

    typedef struct packed {
        logic [7:0]  next_pc;
        logic        print_valid;
        logic [7:0]  print_index;
        logic [31:0] print_value;
        logic        halted;
        logic        div_by_zero;
    } result_t;

endpackage

FILE: rtl/brv_stream_if.sv
// ----------------------------------------------------------------------------
// brv_stream_if
// valid/ready channel carrying one word of a given payload type
// ----------------------------------------------------------------------------
interface brv_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/byte_register_vm_executor.sv
// ----------------------------------------------------------------------------
// byte_register_vm_executor
// executes one decoded instruction per input word on a register file
// ----------------------------------------------------------------------------
// channel  dir  payload
// instr    in   func, first_field, second_field, third_field
// result   out  next_pc, print_valid, print_index, print_value, halted,
//               div_by_zero
//
// an instruction passes the read, execute and output states, plus the
// bit-serial divider state for div or mod with a nonzero divisor
// the next word is taken in the cycle the result is accepted
// reset clears pc, halt flag and register valid bits; no clearing pass
// a stalled result holds the block until taken
module byte_register_vm_executor #(
    parameter int NUM_REGS   = brv_pkg::NUM_REGS_DEF,
    parameter int WORD_BITS  = brv_pkg::WORD_BITS_DEF,
    parameter int PROG_DEPTH = brv_pkg::PROG_DEPTH_DEF
) (
    input logic  clk,
    input logic  rst_n,
    brv_stream_if.sink   instr,
    brv_stream_if.source result
);
    import brv_pkg::*;

    ctrl_t ctrl;
    stat_t stat;
    logic  instr_load;

    brv_control u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (instr.valid),
        .in_ready   (instr.ready),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .stat       (stat),
        .ctrl       (ctrl),
        .instr_load (instr_load)
    );

    brv_datapath #(
        .NUM_REGS   (NUM_REGS),
        .WORD_BITS  (WORD_BITS),
        .PROG_DEPTH (PROG_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .instr      (instr.data),
        .instr_load (instr_load),
        .ctrl       (ctrl),
        .stat       (stat),
        .result     (result.data)
    );
endmodule

FILE: rtl/brv_divider.sv
// ----------------------------------------------------------------------------
// brv_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module brv_divider #(
    parameter int WORD_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] dividend,
    input  logic [WORD_BITS-1:0] divisor,
    output logic                 done,
    output logic [WORD_BITS-1:0] quotient,
    output logic [WORD_BITS-1:0] remainder
);
    localparam int CW = $clog2(WORD_BITS + 1);

    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [WORD_BITS-1:0] q_reg, q_next, r_reg, r_next, d_reg;
    logic [WORD_BITS:0]   trial;

    always_comb
    begin
        trial     = {r_reg, q_reg[WORD_BITS-1]} - {1'b0, d_reg};
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            cnt_next  = CW'(WORD_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[WORD_BITS])
            begin
                r_next = {r_reg[WORD_BITS-2:0], q_reg[WORD_BITS-1]};
                q_next = {q_reg[WORD_BITS-2:0], 1'b0};
            end
            else
            begin
                r_next = trial[WORD_BITS-1:0];
                q_next = {q_reg[WORD_BITS-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start)
            d_reg <= divisor;
    end

    assign done      = busy_reg && cnt_reg == CW'(1);
    assign quotient  = q_next;
    assign remainder = r_next;
endmodule

FILE: rtl/brv_datapath.sv
// ----------------------------------------------------------------------------
// brv_datapath
// register file, pc, halt flag, alu and result register
// ----------------------------------------------------------------------------
module brv_datapath #(
    parameter int NUM_REGS   = 256,
    parameter int WORD_BITS  = 32,
    parameter int PROG_DEPTH = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  brv_pkg::instr_t  instr,
    input  logic             instr_load,
    input  brv_pkg::ctrl_t   ctrl,
    output brv_pkg::stat_t   stat,
    output brv_pkg::result_t result
);
    import brv_pkg::*;

    localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int PW = (PROG_DEPTH > 1) ? $clog2(PROG_DEPTH) : 1;
    localparam int SW = $clog2(WORD_BITS);
    // reciprocals for reducing a byte modulo the register and program depths
    localparam int REG_RCP = (65536 + NUM_REGS - 1) / NUM_REGS;
    localparam int PC_RCP  = (65536 + PROG_DEPTH - 1) / PROG_DEPTH;

    // register file in memory, valid bits emulate the all-zero reset
    logic [WORD_BITS-1:0] mem [NUM_REGS];
    logic [NUM_REGS-1:0]  vld_reg;

    instr_t               ins_reg;
    logic [WORD_BITS-1:0] a_raw, b_raw, a, b;
    logic                 va_reg, vb_reg;
    logic [PW-1:0]        pc_reg, pc_next;
    logic                 halt_reg;
    result_t              res_reg, res_next;

    logic [RW-1:0]        ia, ib, id, wa;
    logic                 we;
    logic [WORD_BITS-1:0] wd;
    logic [PW-1:0]        pc_inc;
    logic                 big_shift;

    logic                 dstart, ddone;
    logic [WORD_BITS-1:0] quo, rem;

    // byte modulo n by reciprocal multiply, exact for any byte and n up to 256
    function automatic logic [7:0] wrap_byte(input logic [7:0] v,
                                             input logic [16:0] rcp,
                                             input logic [8:0] n);
        logic [24:0] prod;
        logic [8:0]  qt;
        logic [17:0] back;
        prod = 25'(v) * 25'(rcp);
        qt   = prod[24:16];
        back = 18'(qt) * 18'(n);
        return 8'(18'(v) - back);
    endfunction

    assign ia = RW'(wrap_byte(ins_reg.first_field, 17'(REG_RCP), 9'(NUM_REGS)));
    assign ib = RW'(wrap_byte(ins_reg.second_field, 17'(REG_RCP), 9'(NUM_REGS)));
    assign id = RW'(wrap_byte(ins_reg.third_field, 17'(REG_RCP), 9'(NUM_REGS)));
    assign a  = va_reg ? a_raw : '0;
    assign b  = vb_reg ? b_raw : '0;
    assign pc_inc    = (pc_reg == PW'(PROG_DEPTH - 1)) ? '0 : pc_reg + 1'b1;
    assign big_shift = b >= WORD_BITS'(WORD_BITS);

    always_ff @(posedge clk)
    begin
        if (instr_load)
            ins_reg <= instr;
        if (ctrl.operand_rd)
        begin
            a_raw <= mem[ia];
            b_raw <= mem[ib];
        end
        if (we)
            mem[wa] <= wd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            va_reg   <= 1'b0;
            vb_reg   <= 1'b0;
            pc_reg   <= '0;
            halt_reg <= 1'b0;
            res_reg  <= '0;
        end
        else
        begin
            if (ctrl.operand_rd)
            begin
                va_reg <= vld_reg[ia];
                vb_reg <= vld_reg[ib];
            end
            if (we)
                vld_reg[wa] <= 1'b1;
            if (ctrl.exec && !halt_reg && op_t'(ins_reg.func) == OP_STALL)
                halt_reg <= 1'b1;
            pc_reg  <= pc_next;
            res_reg <= res_next;
        end
    end

    assign dstart = ctrl.div_start;

    brv_divider #(.WORD_BITS(WORD_BITS)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (dstart),
        .dividend  (a),
        .divisor   (b),
        .done      (ddone),
        .quotient  (quo),
        .remainder (rem)
    );

    assign stat.is_div   = !halt_reg && b != '0 &&
        (op_t'(ins_reg.func) == OP_DIV || op_t'(ins_reg.func) == OP_MOD);
    assign stat.div_done = ddone;

    always_comb
    begin
        we       = 1'b0;
        wa       = id;
        wd       = '0;
        pc_next  = pc_reg;
        res_next = res_reg;
        if (ctrl.out_clear)
            res_next = '0;
        if (ctrl.div_finish)
        begin
            we = 1'b1;
            wd = (op_t'(ins_reg.func) == OP_DIV) ? quo : rem;
            pc_next = pc_inc;
            res_next = '0;
            res_next.next_pc = 8'(pc_inc);
        end
        else if (ctrl.exec)
        begin
            res_next = '0;
            if (halt_reg)
            begin
                res_next.next_pc = 8'(pc_reg);
                res_next.halted  = 1'b1;
            end
            else
            begin
                pc_next = pc_inc;
                case (op_t'(ins_reg.func))
                    OP_ADD: begin we = 1'b1; wd = a + b; end
                    OP_SUB: begin we = 1'b1; wd = a - b; end
                    OP_MUL: begin we = 1'b1; wd = WORD_BITS'(a * b); end
                    OP_DIV, OP_MOD:
                    begin
                        // only the zero-divisor case reaches here
                        we = 1'b1;
                        wd = '0;
                        res_next.div_by_zero = 1'b1;
                    end
                    OP_INC: begin we = 1'b1; wa = ia; wd = a + 1'b1; end
                    OP_NEG: begin we = 1'b1; wa = ia; wd = '0 - a; end
                    OP_JMP:
                        pc_next = PW'(wrap_byte(ins_reg.first_field, 17'(PC_RCP),
                                                9'(PROG_DEPTH)));
                    OP_JNE:
                        if (a != b)
                            pc_next = PW'(wrap_byte(ins_reg.third_field, 17'(PC_RCP),
                                                    9'(PROG_DEPTH)));
                    OP_JE:
                        if (a == b)
                            pc_next = PW'(wrap_byte(ins_reg.third_field, 17'(PC_RCP),
                                                    9'(PROG_DEPTH)));
                    OP_MOV:
                    begin
                        we = 1'b1;
                        wa = ia;
                        wd = WORD_BITS'(ins_reg.second_field);
                    end
                    OP_TST, OP_XOR: begin we = 1'b1; wd = a ^ b; end
                    OP_AND: begin we = 1'b1; wd = a & b; end
                    OP_OR:  begin we = 1'b1; wd = a | b; end
                    OP_NOT:
                    begin
                        we = 1'b1;
                        wa = ib;
                        wd = (a == '0) ? WORD_BITS'(1) : '0;
                    end
                    OP_LSH:
                    begin
                        we = 1'b1;
                        wd = big_shift ? '0 : a << b[SW-1:0];
                    end
                    OP_RSH:
                    begin
                        we = 1'b1;
                        wd = big_shift ? '0 : a >> b[SW-1:0];
                    end
                    OP_PRINT:
                    begin
                        res_next.print_valid = 1'b1;
                        res_next.print_index = 8'(ia);
                        res_next.print_value = 32'(a);
                    end
                    OP_STALL:
                    begin
                        pc_next = pc_reg;
                        res_next.halted = 1'b1;
                    end
                    default: ;
                endcase
                res_next.next_pc = 8'(pc_next);
            end
        end
    end

    assign result = res_reg;
endmodule

FILE: rtl/brv_control.sv
// ----------------------------------------------------------------------------
// brv_control
// sequencer: read operands, execute or run divider, present output word
// ----------------------------------------------------------------------------
module brv_control (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  brv_pkg::stat_t stat,
    output brv_pkg::ctrl_t ctrl,
    output logic           instr_load
);
    import brv_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_READ;
            ST_READ: state_next = ST_EXEC;
            ST_EXEC: state_next = stat.is_div ? ST_DIV : ST_OUT;
            ST_DIV:  if (stat.div_done) state_next = ST_OUT;
            ST_OUT:  if (out_ready) state_next = in_valid ? ST_READ : ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl       = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_READ: ctrl.operand_rd = 1'b1;
            ST_EXEC:
            begin
                ctrl.exec      = !stat.is_div;
                ctrl.div_start = stat.is_div;
            end
            ST_DIV: ctrl.div_finish = stat.div_done;
            ST_OUT:
            begin
                out_valid      = 1'b1;
                in_ready       = out_ready;
                ctrl.out_clear = out_ready;
            end
            default: ;
        endcase
        instr_load = in_ready && in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end
endmodule

FILE: rtl/brv_checker.sv
// ----------------------------------------------------------------------------
// brv_checker
// port-level checks of the executor
// ----------------------------------------------------------------------------
module brv_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input brv_pkg::result_t res
);
    // output word stays while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(res))
        else $error("result changed while stalled");

    // no new word accepted while a result waits
    a_noacc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result pending");

    // result never in the cycle after acceptance
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("result too early");

    // once halted, stays halted
    a_halt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && res.halted |=> !out_valid || res.halted)
        else $error("halt flag dropped");

    // print fields clear when no print
    a_print: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !res.print_valid |-> res.print_index == '0 &&
        res.print_value == '0)
        else $error("print fields not cleared");
endmodule

bind byte_register_vm_executor brv_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (instr.valid),
    .in_ready  (instr.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .res       (result.data)
);

FILE: sim/brv_exec_checker.sv
// ----------------------------------------------------------------------------
// brv_exec_checker
// watches the instruction and result channels, runs its own model of the
// register machine on every accepted word and compares each result word
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module brv_exec_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  brv_pkg::instr_t  in_word,
    input  logic             out_valid,
    input  logic             out_ready,
    input  brv_pkg::result_t out_word,
    output int               fail_count,
    output int               pending_count,
    output int               result_count,
    output int               print_count,
    output int               dz_count
);
    import brv_pkg::*;

    logic [31:0] regs [256];
    logic [7:0]  pc;
    logic        halt;
    result_t     expected_results [$];

    function automatic result_t execute(instr_t w);
        result_t     r;
        logic [31:0] a;
        logic [31:0] b;
        logic [7:0]  nxt;
        op_t         op;
        a   = regs[w.first_field];
        b   = regs[w.second_field];
        nxt = pc + 8'd1;
        r   = '0;
        op  = op_t'(w.func);
        if (halt)
            nxt = pc;
        else
        begin
            case (op)
                OP_ADD:   regs[w.third_field] = a + b;
                OP_SUB:   regs[w.third_field] = a - b;
                OP_MUL:   regs[w.third_field] = a * b;
                OP_DIV, OP_MOD:
                begin
                    if (b == 0)
                    begin
                        regs[w.third_field] = '0;
                        r.div_by_zero = 1'b1;
                    end
                    else
                        regs[w.third_field] = (op == OP_DIV) ? a / b : a % b;
                end
                OP_INC:   regs[w.first_field] = a + 1;
                OP_NEG:   regs[w.first_field] = -a;
                OP_JMP:   nxt = w.first_field;
                OP_JNE:   if (a != b) nxt = w.third_field;
                OP_JE:    if (a == b) nxt = w.third_field;
                OP_MOV:   regs[w.first_field] = {24'd0, w.second_field};
                OP_TST, OP_XOR: regs[w.third_field] = a ^ b;
                OP_AND:   regs[w.third_field] = a & b;
                OP_OR:    regs[w.third_field] = a | b;
                OP_NOT:   regs[w.second_field] = (a == 0) ? 32'd1 : 32'd0;
                OP_LSH:   regs[w.third_field] = (b >= 32) ? '0 : a << b[4:0];
                OP_RSH:   regs[w.third_field] = (b >= 32) ? '0 : a >> b[4:0];
                OP_PRINT:
                begin
                    r.print_valid = 1'b1;
                    r.print_index = w.first_field;
                    r.print_value = a;
                end
                OP_STALL:
                begin
                    halt = 1'b1;
                    nxt  = pc;
                end
                default: ;
            endcase
            pc = nxt;
        end
        r.next_pc = nxt;
        r.halted  = halt;
        return r;
    endfunction

    assign pending_count = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        result_t e;
        if (!rst_n)
        begin
            foreach (regs[i]) regs[i] = '0;
            pc = '0;
            halt = 1'b0;
            expected_results.delete();
            fail_count   <= 0;
            result_count <= 0;
            print_count  <= 0;
            dz_count     <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_results.push_back(execute(in_word));
            if (out_valid && out_ready)
            begin
                result_count <= result_count + 1;
                if (expected_results.size() == 0)
                begin
                    $error("result word with nothing expected");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (out_word.print_valid) print_count <= print_count + 1;
                    if (out_word.div_by_zero) dz_count <= dz_count + 1;
                    if (out_word !== e)
                    begin
                        fail_count <= fail_count + 1;
                        if (out_word.next_pc !== e.next_pc)
                            $error("next_pc exp %0d got %0d", e.next_pc, out_word.next_pc);
                        if (out_word.print_valid !== e.print_valid)
                            $error("print_valid exp %0d got %0d",
                                   e.print_valid, out_word.print_valid);
                        if (out_word.print_index !== e.print_index)
                            $error("print_index exp %0d got %0d",
                                   e.print_index, out_word.print_index);
                        if (out_word.print_value !== e.print_value)
                            $error("print_value exp %h got %h",
                                   e.print_value, out_word.print_value);
                        if (out_word.halted !== e.halted)
                            $error("halted exp %0d got %0d", e.halted, out_word.halted);
                        if (out_word.div_by_zero !== e.div_by_zero)
                            $error("div_by_zero exp %0d got %0d",
                                   e.div_by_zero, out_word.div_by_zero);
                    end
                end
            end
        end
    end

endmodule

FILE: sim/byte_register_vm_executor_test.sv
// ----------------------------------------------------------------------------
// byte_register_vm_executor_test
// drives directed and random instruction streams with varying idle and
// stall patterns; the checker predicts and compares every result word
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module byte_register_vm_executor_test;
    import brv_pkg::*;

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   sent_count;
    int   idle_pct;
    int   stall_pct;
    bit   hold_off;
    int   fail_count;
    int   pending_count;
    int   result_count;
    int   print_count;
    int   dz_count;

    brv_stream_if #(.payload_t(instr_t))  instr ();
    brv_stream_if #(.payload_t(result_t)) result ();

    byte_register_vm_executor uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr.sink),
        .result (result.source)
    );

    brv_exec_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (instr.valid),
        .in_ready      (instr.ready),
        .in_word       (instr.data),
        .out_valid     (result.valid),
        .out_ready     (result.ready),
        .out_word      (result.data),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .result_count  (result_count),
        .print_count   (print_count),
        .dz_count      (dz_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 1500000)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("** byte_register_vm_executor: FAILED **");
                $finish;
            end
        end
    end

    // receiver: random stalls, or a long hold-off when asked
    initial
    begin
        result.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
                result.ready <= 1'b0;
            else
                result.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // small register indices mostly, so values get reused
    function automatic logic [7:0] pick_reg();
        return ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7));
    endfunction

    task automatic send(input op_t op, input logic [7:0] f1, input logic [7:0] f2,
                        input logic [7:0] f3);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            instr.valid <= 1'b0;
            @(posedge clk);
        end
        instr.valid <= 1'b1;
        instr.data  <= '{func: op, first_field: f1, second_field: f2, third_field: f3};
        @(posedge clk);
        while (!instr.ready) @(posedge clk);
        sent_count++;
    endtask

    task automatic send_random();
        op_t        op;
        int         k;
        logic [7:0] b;
        k = $urandom_range(99);
        if (k < 3)
            op = op_t'(5'($urandom_range(31, 21)));
        else
            op = op_t'(5'($urandom_range(19)));
        b = pick_reg();
        if (op == OP_MOV)
            send(op, pick_reg(), 8'($urandom), pick_reg());
        else if ((op == OP_LSH || op == OP_RSH) && $urandom_range(1))
        begin
            send(OP_MOV, b, 8'($urandom_range(40)), 8'd0);
            send(op, pick_reg(), b, pick_reg());
        end
        else
            send(op, pick_reg(), b, pick_reg());
    endtask

    task automatic drain();
        instr.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        instr.valid = 1'b0;
        instr.data  = '0;
        idle_pct    = 0;
        stall_pct   = 0;
        hold_off    = 1'b0;
        sent_count  = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every opcode but stall, zero divisor, large shift
        send(OP_MOV, 8'd1, 8'hff, 8'd0);
        send(OP_MOV, 8'd255, 8'd7, 8'd0);
        send(OP_NEG, 8'd2, 8'd0, 8'd0);
        send(OP_ADD, 8'd1, 8'd2, 8'd3);
        send(OP_SUB, 8'd0, 8'd1, 8'd4);
        send(OP_MUL, 8'd4, 8'd4, 8'd5);
        send(OP_DIV, 8'd4, 8'd255, 8'd6);
        send(OP_MOD, 8'd4, 8'd255, 8'd7);
        send(OP_DIV, 8'd4, 8'd9, 8'd8);
        send(OP_MOD, 8'd4, 8'd9, 8'd8);
        send(OP_INC, 8'd2, 8'd0, 8'd0);
        send(OP_JMP, 8'd255, 8'd0, 8'd0);
        send(OP_JNE, 8'd1, 8'd2, 8'd200);
        send(OP_JE, 8'd9, 8'd10, 8'd17);
        send(OP_TST, 8'd1, 8'd4, 8'd11);
        send(OP_AND, 8'd1, 8'd4, 8'd12);
        send(OP_OR, 8'd1, 8'd255, 8'd13);
        send(OP_XOR, 8'd4, 8'd4, 8'd14);
        send(OP_NOT, 8'd14, 8'd15, 8'd0);
        send(OP_LSH, 8'd4, 8'd1, 8'd16);
        send(OP_RSH, 8'd4, 8'd15, 8'd17);
        send(OP_PRINT, 8'd4, 8'd0, 8'd0);
        send(OP_PRINT, 8'd255, 8'd0, 8'd0);
        send(op_t'(5'd31), 8'd0, 8'd0, 8'd0);
        send(OP_NONE, 8'd0, 8'd0, 8'd0);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 15 : 83) : 0;
            stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 15 : 83) : 0;
            for (int i = 0; i < 420; i++)
                send_random();
            if (ph == 0)
            begin
                // long receiver hold-off while words keep coming
                hold_off = 1'b1;
                fork
                    repeat (300) @(posedge clk);
                    for (int i = 0; i < 20; i++) send_random();
                join_any
                hold_off = 1'b0;
                wait fork;
            end
            drain();
        end

        // stall, then instructions that must be ignored
        send(OP_STALL, 8'd0, 8'd0, 8'd0);
        for (int i = 0; i < 10; i++)
            send_random();
        drain();

        $display("sent %0d instructions, %0d results, %0d prints, %0d zero divisors",
                 sent_count, result_count, print_count, dz_count);
        if (fail_count == 0)
            $display("** byte_register_vm_executor: PASSED **");
        else
            $display("** byte_register_vm_executor: FAILED **");
        $finish;
    end

endmodule
